// ===== rtl/format_string_number_formatter_assert.svh =====
// Assertion macros for the formatter RTL, used by the emitter.
// Each macro expects clk and rst_n to be visible in the including module.
`ifndef FORMAT_STRING_NUMBER_FORMATTER_ASSERT_SVH
`define FORMAT_STRING_NUMBER_FORMATTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSNF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSNF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fsnf_pkg.sv =====
// Types, constants and helper functions for the format string formatter.
// No dependencies; used by fsnf_cell, fsnf_emit and the top level.
`timescale 1ns / 1ps

package fsnf_pkg;

  localparam int BIN_W      = 32;
  localparam int DEC_DIGITS = 10;
  localparam int BCD_W      = 4 * DEC_DIGITS;
  localparam int HEX_DIGITS = 8;
  localparam int IDX_W      = 4;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPEC_U  = 8'h75;
  localparam logic [7:0] CH_SPEC_D  = 8'h64;
  localparam logic [7:0] CH_SPEC_X  = 8'h78;
  localparam logic [7:0] CH_SPEC_C  = 8'h63;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_HEX_A   = 8'h37;

  localparam logic [IDX_W-1:0] IDX_SIGN     = 4'd0;
  localparam logic [IDX_W-1:0] IDX_PREFIX_X = 4'd1;
  localparam logic [IDX_W-1:0] IDX_DEC_LAST = 4'd10;
  localparam logic [IDX_W-1:0] IDX_HEX_LAST = 4'd9;

  typedef enum logic [2:0] {
    KIND_CHAR = 3'b001,
    KIND_DEC  = 3'b010,
    KIND_HEX  = 3'b100
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               neg;
    logic [7:0]         ch;
    logic [BIN_W-1:0]   arg;
    logic [BIN_W-1:0]   bin;
    logic [BCD_W-1:0]   bcd;
  } item_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + {4'b0000, nib};
    end
    return CH_HEX_A + {4'b0000, nib};
  endfunction

endpackage

// ===== rtl/fsnf_if.sv =====
// Valid/ready channel interfaces for the formatter's input and result streams.
// No dependencies.
`timescale 1ns / 1ps

interface fsnf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  fmt_char;
  logic [31:0] argument;

  modport source (output valid, output fmt_char, output argument, input ready);
  modport sink (input valid, input fmt_char, input argument, output ready);
endinterface

interface fsnf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

// ===== rtl/fsnf_cell.sv =====
// One double-dabble cell: adds three to each BCD digit of five or more, then
// shifts one binary bit into the BCD word. Depends on fsnf_pkg.
`timescale 1ns / 1ps

module fsnf_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  fsnf_pkg::item_t in_data,
  output logic            out_valid,
  output fsnf_pkg::item_t out_data
);

  logic                       valid_r;
  fsnf_pkg::item_t            data_r;
  fsnf_pkg::item_t            data_nxt;
  logic [fsnf_pkg::BCD_W-1:0] adj;

  always_comb begin
    adj = in_data.bcd;
    for (int d = 0; d < fsnf_pkg::DEC_DIGITS; d++) begin
      if (adj[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
    end
    data_nxt     = in_data;
    data_nxt.bcd = {adj[fsnf_pkg::BCD_W-2:0], in_data.bin[fsnf_pkg::BIN_W-1]};
    data_nxt.bin = {in_data.bin[fsnf_pkg::BIN_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== rtl/fsnf_emit.sv =====
// Character emitter: takes finished items from the end of the cell row and
// sends their characters one per transfer. Depends on fsnf_pkg and the macros.
`timescale 1ns / 1ps
`include "format_string_number_formatter_assert.svh"

module fsnf_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            src_valid,
  input  fsnf_pkg::item_t src_data,
  output logic            take,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [7:0]      out_char,
  output logic            out_last
);

  logic                       busy_r, busy_nxt;
  logic [fsnf_pkg::IDX_W-1:0] idx_r, idx_nxt;
  fsnf_pkg::item_t            item_r;
  logic                       ov_r, ov_nxt;
  logic [7:0]                 oc_r;
  logic                       ol_r;

  logic [fsnf_pkg::IDX_W-1:0] last_idx;
  logic [fsnf_pkg::IDX_W-1:0] start_idx;
  logic [fsnf_pkg::IDX_W-1:0] dsel;
  logic [2:0]                 nsel;
  logic                       is_last;
  logic                       step;
  logic [7:0]                 cur_char;

  always_comb begin
    case (item_r.kind)
      fsnf_pkg::KIND_DEC: last_idx = fsnf_pkg::IDX_DEC_LAST;
      fsnf_pkg::KIND_HEX: last_idx = fsnf_pkg::IDX_HEX_LAST;
      default:            last_idx = fsnf_pkg::IDX_SIGN;
    endcase
  end

  assign is_last   = (idx_r == last_idx);
  assign step      = busy_r && (!ov_r || out_ready);
  assign take      = src_valid && (!busy_r || (step && is_last));
  assign start_idx = (src_data.kind == fsnf_pkg::KIND_DEC && !src_data.neg) ?
                     fsnf_pkg::IDX_PREFIX_X : fsnf_pkg::IDX_SIGN;
  assign dsel      = fsnf_pkg::IDX_DEC_LAST - idx_r;
  assign nsel      = 3'(fsnf_pkg::IDX_HEX_LAST - idx_r);

  always_comb begin
    case (item_r.kind)
      fsnf_pkg::KIND_DEC: begin
        if (idx_r == fsnf_pkg::IDX_SIGN) begin
          cur_char = fsnf_pkg::CH_MINUS;
        end else begin
          cur_char = fsnf_pkg::CH_ZERO + {4'b0000, item_r.bcd[{dsel, 2'b00} +: 4]};
        end
      end
      fsnf_pkg::KIND_HEX: begin
        if (idx_r == fsnf_pkg::IDX_SIGN) begin
          cur_char = fsnf_pkg::CH_ZERO;
        end else if (idx_r == fsnf_pkg::IDX_PREFIX_X) begin
          cur_char = fsnf_pkg::CH_LOWER_X;
        end else begin
          cur_char = fsnf_pkg::hex_char(item_r.arg[{nsel, 2'b00} +: 4]);
        end
      end
      default: cur_char = item_r.ch;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (step) begin
      idx_nxt = idx_r + 4'd1;
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (take) begin
      busy_nxt = 1'b1;
      idx_nxt  = start_idx;
    end
    ov_nxt = step ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (take) begin
      item_r <= src_data;
    end
    if (step) begin
      oc_r <= cur_char;
      ol_r <= is_last;
    end
  end

  assign out_valid = ov_r;
  assign out_char  = oc_r;
  assign out_last  = ol_r;

  `FSNF_ASSERT_NEXT(a_take_sets_busy, take, busy_r, "Emitter did not start a taken item.")
  `FSNF_ASSERT_NOW(a_idx_range, busy_r, idx_r <= fsnf_pkg::IDX_DEC_LAST, "Emitter index overran.")
  `FSNF_ASSERT_NEXT(a_stall_holds, busy_r && ov_r && !out_ready,
                    busy_r && $stable(idx_r), "Emitter advanced while the output stalled.")

endmodule

// ===== rtl/format_string_number_formatter.sv =====
// Top level of the streaming printf-style integer formatter.
// Depends on fsnf_pkg, fsnf_if, fsnf_cell and fsnf_emit.
`timescale 1ns / 1ps

// Each input transfer carries one format character and a 32-bit argument. A
// percent sign and an unknown specifier after it produce no output. Accepted
// items pass through a row of 32 double-dabble cells, one cell per argument
// bit, and are registered in each cell, then in the emitter's item and output
// registers. Characters then leave at one per cycle while the result channel
// is ready: an item sends 1 character (echo, %c), 10 characters (%u, %x,
// positive %d) or 11 characters (negative %d), and a new item can enter every
// cycle that the row is not held up by a waiting item at its end.
module format_string_number_formatter (
  input  logic              clk,
  input  logic              rst_n,
  fsnf_in_if.sink           in_ch,
  fsnf_out_if.source        out_ch
);

  localparam int NCELL = fsnf_pkg::BIN_W;

  logic            after_percent_r, after_percent_nxt;
  logic            accept;
  logic            en;
  logic            take;
  logic            push;
  fsnf_pkg::item_t head;
  logic            cv [0:NCELL];
  fsnf_pkg::item_t cd [0:NCELL];

  assign en          = !cv[NCELL] || take;
  assign in_ch.ready = en;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    head      = '0;
    head.kind = fsnf_pkg::KIND_CHAR;
    head.neg  = 1'b0;
    head.ch   = in_ch.fmt_char;
    head.arg  = in_ch.argument;
    head.bin  = in_ch.argument;
    head.bcd  = '0;
    push      = 1'b0;
    if (!after_percent_r) begin
      push = (in_ch.fmt_char != fsnf_pkg::CH_PERCENT);
    end else begin
      case (in_ch.fmt_char)
        fsnf_pkg::CH_SPEC_U: begin
          head.kind = fsnf_pkg::KIND_DEC;
          push      = 1'b1;
        end
        fsnf_pkg::CH_SPEC_D: begin
          head.kind = fsnf_pkg::KIND_DEC;
          head.neg  = in_ch.argument[fsnf_pkg::BIN_W-1];
          if (in_ch.argument[fsnf_pkg::BIN_W-1]) begin
            head.bin = 32'd0 - in_ch.argument;
          end
          push = 1'b1;
        end
        fsnf_pkg::CH_SPEC_X: begin
          head.kind = fsnf_pkg::KIND_HEX;
          push      = 1'b1;
        end
        fsnf_pkg::CH_SPEC_C: begin
          head.ch = in_ch.argument[7:0];
          push    = 1'b1;
        end
        default: push = 1'b0;
      endcase
    end
    after_percent_nxt = accept ?
                        (!after_percent_r && in_ch.fmt_char == fsnf_pkg::CH_PERCENT) :
                        after_percent_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_percent_r <= 1'b0;
    end else begin
      after_percent_r <= after_percent_nxt;
    end
  end

  assign cv[0] = accept && push;
  assign cd[0] = head;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    fsnf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (cv[i]),
      .in_data   (cd[i]),
      .out_valid (cv[i+1]),
      .out_data  (cd[i+1])
    );
  end

  fsnf_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (cv[NCELL]),
    .src_data  (cd[NCELL]),
    .take      (take),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_char  (out_ch.out_char),
    .out_last  (out_ch.last)
  );

endmodule
